@@ rtl/hnba_pkg.sv @@
// Package for the heap node block allocator: sizes, status codes, the result
// record and the block header size function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hnba_pkg;

    // Usable bytes in one heap block
    localparam int unsigned BLOCK_CAPACITY = 8176;

    // Header sizes: first block, bitmap blocks, ordinary page blocks
    localparam int unsigned FIRST_HDR  = 12;
    localparam int unsigned PAGE_HDR   = 2;
    localparam int unsigned BITMAP_HDR = 2 + 64;

    // Bitmap blocks sit at 8, 136, 264, ...
    localparam int unsigned BITMAP_PERIOD = 128;
    localparam int unsigned BITMAP_FIRST  = 8;
    localparam int unsigned PERIOD_W      = $clog2(BITMAP_PERIOD);

    localparam int unsigned MAX_SLOTS = 2047;
    localparam int unsigned MAX_BLOCK = 'hFFFF;

    // Worst case overhead: bitmap header, page map for one allocation, pad byte
    localparam int unsigned WORST_OVER = BITMAP_HDR + (4 + 2 * 2) + 1;
    localparam int unsigned LARGEST_ALLOC =
        (BLOCK_CAPACITY > WORST_OVER) ? BLOCK_CAPACITY - WORST_OVER : 0;

    // Field widths
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned BLOCK_W  = 16;
    localparam int unsigned USED_W   = 14;
    localparam int unsigned COUNT_W  = 11;
    localparam int unsigned HEAPID_W = 32;
    localparam int unsigned HDR_W    = 7;
    localparam int unsigned NEED_W   = 18;

    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 64;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TOO_LARGE = 2'd1,
        STATUS_EXHAUSTED = 2'd2
    } status_t;

    typedef struct packed {
        logic                opened_new;
        logic [HEAPID_W-1:0] heap_id;
        logic [COUNT_W-1:0]  slot_number;
        logic [BLOCK_W-1:0]  block_number;
        status_t             status;
    } alloc_result_t;

    // Header bytes of a given block
    function automatic logic [HDR_W-1:0] header_bytes(input logic [BLOCK_W-1:0] blk);
        logic [HDR_W-1:0] hdr;
        if (blk == '0) begin
            hdr = HDR_W'(FIRST_HDR);
        end else if (blk[PERIOD_W-1:0] == PERIOD_W'(BITMAP_FIRST)) begin
            hdr = HDR_W'(BITMAP_HDR);
        end else begin
            hdr = HDR_W'(PAGE_HDR);
        end
        return hdr;
    endfunction

endpackage

`default_nettype wire

@@ rtl/hnba_alloc_core.sv @@
// Allocation state (open block, bytes used, allocation count) and the
// combinational fit decision. Depends on hnba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hnba_alloc_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          fire,
    input  wire logic [hnba_pkg::LEN_W-1:0]    length,
    output hnba_pkg::alloc_result_t            result
);

    logic [hnba_pkg::BLOCK_W-1:0] open_block_reg, open_block_next;
    logic [hnba_pkg::USED_W-1:0]  bytes_used_reg, bytes_used_next;
    logic [hnba_pkg::COUNT_W-1:0] slot_count_reg, slot_count_next;

    logic [hnba_pkg::NEED_W-1:0]  need;
    logic                         too_large;
    logic                         full;
    logic                         exhausted;
    logic [hnba_pkg::BLOCK_W-1:0] blk;
    logic [hnba_pkg::COUNT_W-1:0] slot;
    logic [hnba_pkg::USED_W-1:0]  used_base;

    // Bytes the open block would need: header + data + page map + pad
    assign need = hnba_pkg::NEED_W'(hnba_pkg::header_bytes(open_block_reg))
                + hnba_pkg::NEED_W'(bytes_used_reg)
                + hnba_pkg::NEED_W'(length)
                + {(hnba_pkg::NEED_W-1)'(slot_count_reg), 1'b0}
                + hnba_pkg::NEED_W'(9);

    assign too_large = length > hnba_pkg::LEN_W'(hnba_pkg::LARGEST_ALLOC);
    assign full      = (need > hnba_pkg::NEED_W'(hnba_pkg::BLOCK_CAPACITY))
                    || (slot_count_reg == hnba_pkg::COUNT_W'(hnba_pkg::MAX_SLOTS));
    assign exhausted = full && (open_block_reg == hnba_pkg::BLOCK_W'(hnba_pkg::MAX_BLOCK));

    // Target block and slot
    assign blk       = full ? open_block_reg + 1'b1 : open_block_reg;
    assign slot      = full ? hnba_pkg::COUNT_W'(1) : slot_count_reg + 1'b1;
    assign used_base = full ? '0 : bytes_used_reg;

    // Result record
    always_comb begin
        result = '0;
        if (too_large) begin
            result.status = hnba_pkg::STATUS_TOO_LARGE;
        end else if (exhausted) begin
            result.status = hnba_pkg::STATUS_EXHAUSTED;
        end else begin
            result.status       = hnba_pkg::STATUS_OK;
            result.block_number = blk;
            result.slot_number  = slot;
            result.heap_id      = {blk, slot, 5'b0};
            result.opened_new   = full;
        end
    end

    // State update on an accepted, successful request
    always_comb begin
        open_block_next = open_block_reg;
        bytes_used_next = bytes_used_reg;
        slot_count_next = slot_count_reg;
        if (fire && !too_large && !exhausted) begin
            open_block_next = blk;
            bytes_used_next = used_base + length[hnba_pkg::USED_W-1:0];
            slot_count_next = slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_block_reg <= '0;
            bytes_used_reg <= '0;
            slot_count_reg <= '0;
        end else begin
            open_block_reg <= open_block_next;
            bytes_used_reg <= bytes_used_next;
            slot_count_reg <= slot_count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/heap_node_block_allocator.sv @@
// Top level of the heap node block allocator: input register, allocation
// core and result register. Depends on hnba_pkg and hnba_alloc_core.
//
// Usage:
//   s_ channel carries one allocation length per transfer; m_ channel returns
//   one result per request: status, block number, 1-based slot, packed heap
//   id and a new-block flag.
//   The length is registered at the input transfer; the fit decision and
//   state update then load the result register, which drives m_tvalid.
//   Throughput is one request per cycle while the result register is free
//   or m_tready is high; the three state registers are updated in the same
//   cycle the result is loaded, so the next request sees them at once.
//   When the receiver stalls, the result register holds its transfer and the
//   input register holds one more request; s_tready then drops until
//   m_tready returns (s_tready depends combinationally on m_tready).
//   Reset (aresetn low, synchronous) empties both registers and reopens
//   block 0 with no bytes and no allocations.
`timescale 1ns / 1ps
`default_nettype none

module heap_node_block_allocator (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // tdata: length[15:0]
    input  wire logic [hnba_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // tdata: status[1:0], block_number[17:2], slot_number[28:18],
    //        heap_id[60:29], opened_new[61], zero[63:62]
    output logic [hnba_pkg::OUT_TDATA_W-1:0]         m_tdata
);

    localparam int unsigned RES_W = $bits(hnba_pkg::alloc_result_t);

    logic                         in_valid_reg, in_valid_next;
    logic [hnba_pkg::LEN_W-1:0]   in_length_reg;
    logic                         out_valid_reg, out_valid_next;
    hnba_pkg::alloc_result_t      out_result_reg;
    hnba_pkg::alloc_result_t      core_result;
    logic                         advance;
    logic                         s_fire;

    // Move the held request into the result register when it is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    hnba_alloc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .length  (in_length_reg),
        .result  (core_result)
    );

    // Valid flags
    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_length_reg <= s_tdata[hnba_pkg::LEN_W-1:0];
        end
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(hnba_pkg::OUT_TDATA_W - RES_W)'(0), out_result_reg};

endmodule

`default_nettype wire

@@ rtl/hnba_checker.sv @@
// Port-level checks for heap_node_block_allocator, bound to the top level.
// Depends on hnba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hnba_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic [hnba_pkg::IN_TDATA_W-1:0]   s_tdata,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [hnba_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    logic [1:0]  st;
    logic [15:0] blk;
    logic [10:0] slot;
    logic [31:0] hid;
    logic        opened;

    assign st     = m_tdata[1:0];
    assign blk    = m_tdata[17:2];
    assign slot   = m_tdata[28:18];
    assign hid    = m_tdata[60:29];
    assign opened = m_tdata[61];

    // No result is shown right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A failed request carries no block, slot, id or new-block flag
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st == hnba_pkg::STATUS_TOO_LARGE || st == hnba_pkg::STATUS_EXHAUSTED)
        |-> blk == '0 && slot == '0 && hid == '0 && !opened)
        else $error("error result with nonzero payload");

    // A good result packs block and slot into the heap id, slot is 1-based
    a_ok_pack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st == hnba_pkg::STATUS_OK
        |-> hid == {blk, slot, 5'b0} && slot != '0 && (!opened || slot == 11'd1))
        else $error("bad heap id packing");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // An accepted length is fully known
    a_in_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !$isunknown(s_tdata))
        else $error("unknown length on input transfer");

endmodule

bind heap_node_block_allocator hnba_checker u_hnba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ sim/heap_node_block_allocator_tb.sv @@
// Self-checking bench for heap_node_block_allocator: a tracker class predicts
// each heap id grant from the accepted lengths. Needs hnba_pkg and the RTL.
`timescale 1ns / 1ps

module heap_node_block_allocator_tb;

    // Heap layout figures, kept apart from the RTL except the block capacity
    localparam int unsigned HDR_FIRST     = 12;
    localparam int unsigned HDR_PLAIN     = 2;
    localparam int unsigned HDR_BITMAP    = 66;
    localparam int unsigned FIRST_BITMAP  = 8;
    localparam int unsigned BITMAP_STRIDE = 128;
    localparam int unsigned SLOT_LIMIT    = 2047;
    localparam logic [15:0] LAST_BLOCK    = 16'hFFFF;
    // Worst case: bitmap header, map for one allocation, pad byte
    localparam int unsigned LEN_LIMIT     = hnba_pkg::BLOCK_CAPACITY - (HDR_BITMAP + 8 + 1);

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;

    // Idle shaping shared by both sides
    bit no_idle;
    bit short_idle;

    // Tracks the open block and predicts each grant
    class heap_id_tracker;
        logic [15:0]             open_block;
        logic [13:0]             bytes_used;
        logic [10:0]             slot_count;
        hnba_pkg::alloc_result_t expected_grants[$];
        int                      mismatches;

        function new();
            open_block = '0;
            bytes_used = '0;
            slot_count = '0;
            mismatches = 0;
        endfunction

        function int unsigned header_size(logic [15:0] blk);
            if (blk == 0) return HDR_FIRST;
            if (blk >= FIRST_BITMAP && (blk - FIRST_BITMAP) % BITMAP_STRIDE == 0)
                return HDR_BITMAP;
            return HDR_PLAIN;
        endfunction

        // Largest length that still fits the open block, negative if none
        function int fit_room();
            int r;
            r = int'(hnba_pkg::BLOCK_CAPACITY) - int'(header_size(open_block))
                - int'(bytes_used) - (4 + 2 * (int'(slot_count) + 2)) - 1;
            if (slot_count >= SLOT_LIMIT) r = -1;
            if (r > int'(LEN_LIMIT)) r = int'(LEN_LIMIT);
            return r;
        endfunction

        function void note_request(logic [15:0] len);
            int unsigned             need;
            hnba_pkg::alloc_result_t grant;
            grant = '0;
            if (len > LEN_LIMIT) begin
                grant.status = hnba_pkg::STATUS_TOO_LARGE;
            end else begin
                need = header_size(open_block) + bytes_used + len
                       + 4 + 2 * (slot_count + 2) + 1;
                if (need > hnba_pkg::BLOCK_CAPACITY || slot_count >= SLOT_LIMIT) begin
                    if (open_block == LAST_BLOCK) begin
                        grant.status = hnba_pkg::STATUS_EXHAUSTED;
                    end else begin
                        open_block = open_block + 1;
                        bytes_used = '0;
                        slot_count = '0;
                        grant.opened_new = 1'b1;
                    end
                end
                if (grant.status == hnba_pkg::STATUS_OK) begin
                    bytes_used = bytes_used + len;
                    slot_count = slot_count + 1;
                    grant.block_number = open_block;
                    grant.slot_number  = slot_count;
                    grant.heap_id      = {open_block, slot_count, 5'b0};
                end
            end
            expected_grants = {expected_grants, grant};
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s expected %0h got %0h", $time, field, want, got);
            end
        endfunction

        function void check_grant(logic [63:0] word);
            hnba_pkg::alloc_result_t got;
            hnba_pkg::alloc_result_t want;
            got = hnba_pkg::alloc_result_t'(word[61:0]);
            if (expected_grants.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none got %0h", $time, word);
                return;
            end
            want = expected_grants.pop_front();
            compare("status", 32'(want.status), 32'(got.status));
            compare("block_number", 32'(want.block_number), 32'(got.block_number));
            compare("slot_number", 32'(want.slot_number), 32'(got.slot_number));
            compare("heap_id", want.heap_id, got.heap_id);
            compare("opened_new", 32'(want.opened_new), 32'(got.opened_new));
            compare("pad", 32'd0, 32'(word[63:62]));
        endfunction
    endclass

    heap_id_tracker heap_ids = new();

    heap_node_block_allocator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 250 MHz clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Mostly short gaps, a few long ones
    function automatic int idle_cycles();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 94 || short_idle) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stalls, check every transfer
    initial begin : result_side
        int hold;
        hold = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) heap_ids.check_grant(m_tdata);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                hold = idle_cycles();
                m_tready <= (hold == 0);
                if (hold > 0) hold--;
            end
        end
    end

    // One length transfer, after an optional gap
    task automatic push_length(input logic [15:0] len);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= len;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        heap_ids.note_request(len);
    endtask

    // Sender holds off until every grant is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (heap_ids.expected_grants.size() != 0) @(posedge aclk);
    endtask

    task automatic push_exact_fit();
        int room;
        room = heap_ids.fit_room();
        if (room >= 0) push_length(16'(room));
    endtask

    function automatic logic [15:0] random_length();
        int sel;
        int room;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 16'($urandom_range(0, 63));
        if (sel < 75) return 16'($urandom_range(64, 2047));
        if (sel < 85) return 16'($urandom_range(2048, LEN_LIMIT));
        if (sel < 90) begin
            room = heap_ids.fit_room();
            return (room >= 0) ? 16'(room) : 16'd0;
        end
        return 16'($urandom_range(LEN_LIMIT + 1, 65535));
    endfunction

    // Stimulus
    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        no_idle    = 1'b0;
        short_idle = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, oversize lengths, exact fits, bitmap block
        push_length(16'h0000);
        push_length(16'hFFFF);
        push_length(16'(LEN_LIMIT + 1));
        push_length(16'hAAAA);
        push_length(16'h5555);
        push_length(16'd12345);
        push_exact_fit();
        push_length(16'd1);
        push_length(16'(LEN_LIMIT));
        while (heap_ids.open_block < FIRST_BITMAP) push_length(16'(LEN_LIMIT));
        push_exact_fit();
        push_length(16'd0);
        push_length(16'd4000);
        push_exact_fit();
        push_length(16'd1);
        wait_drained();

        // Random mix with idle modes switched now and then
        for (int i = 0; i < 750; i++) begin
            if (i % 40 == 0) begin
                no_idle    = ($urandom_range(0, 3) == 0);
                short_idle = ($urandom_range(0, 1) == 0);
            end
            if (i == 375) wait_drained();
            push_length(random_length());
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (heap_ids.mismatches == 0 && heap_ids.expected_grants.size() == 0) begin
            $display("heap_node_block_allocator_tb: clean");
        end else begin
            $display("heap_node_block_allocator_tb: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("heap_node_block_allocator_tb: errors");
        $finish;
    end

endmodule

@@ files.f @@
rtl/hnba_pkg.sv
rtl/hnba_alloc_core.sv
rtl/heap_node_block_allocator.sv
rtl/hnba_checker.sv
sim/heap_node_block_allocator_tb.sv
